// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check an implication on every rising edge outside reset
`define ASSERT_IMPLY(label, pre, post, msg) \
  `ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

// ===== rtl/core/eit_pkg.sv =====
// ----------------------------------------------------------------------------
// Editable input tape package
// Tape size, derived widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package eit_pkg;

  localparam int TAPE_CELLS = 64;
  localparam int IDX_W      = $clog2(TAPE_CELLS);
  localparam int CNT_W      = $clog2(TAPE_CELLS + 1);
  localparam int POS_W      = 7;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 8;
  localparam int MODE_W     = 3;

  localparam logic [CNT_W-1:0] TAPE_LIM = CNT_W'(TAPE_CELLS);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR     = 3'd0,
    MODE_LEFT      = 3'd1,
    MODE_RIGHT     = 3'd2,
    MODE_BACKSPACE = 3'd3,
    MODE_INSERT    = 3'd4,
    MODE_START_RUN = 3'd5,
    MODE_RUN_STEP  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_LOOK,
    S_RESP
  } seq_state_t;

endpackage

// ===== rtl/core/eit_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one edit or run command word.
// ----------------------------------------------------------------------------
interface eit_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [eit_pkg::MODE_W-1:0]    mode;
  logic [eit_pkg::SYM_W-1:0]     symbol;
  logic                          symbol_allowed;
  logic [eit_pkg::CODE_W-1:0]    state_code;

  modport source (output valid, mode, symbol, symbol_allowed, state_code, input ready);
  modport sink   (input valid, mode, symbol, symbol_allowed, state_code, output ready);
endinterface

// ===== rtl/core/eit_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one tape status word.
// ----------------------------------------------------------------------------
interface eit_res_if;
  logic                          valid;
  logic                          ready;
  logic [eit_pkg::POS_W-1:0]     cursor;
  logic [eit_pkg::POS_W-1:0]     length;
  logic [eit_pkg::SYM_W-1:0]     read_symbol;
  logic [eit_pkg::CODE_W-1:0]    machine_state;
  logic                          run_done;
  logic                          can_run;

  modport source (output valid, cursor, length, read_symbol, machine_state, run_done,
                  can_run, input ready);
  modport sink   (input valid, cursor, length, read_symbol, machine_state, run_done,
                  can_run, output ready);
endinterface

// ===== rtl/core/editable_input_tape_core.sv =====
// ----------------------------------------------------------------------------
// Editable input tape core
// Symbol tape in a one-read, one-write memory with cursor, length and machine
// state, edited and stepped by one command word at a time.
// ----------------------------------------------------------------------------
// One command word is taken at a time; cmd.ready is high only while the core
// is idle and out of reset. Clear, left, right, start run, run step, the
// unused code and refused edits go from acceptance through the exec and look
// states before the result word is offered on res. A backspace or insert
// that changes the tape also passes through the shift state, which moves the
// tail of the tape one cell per cycle through the tape memory (one read and
// one write a cycle). The memory has no reset; cells at or past the length
// are never shown.
module editable_input_tape_core (
  input logic       clk,
  input logic       rst,
  eit_cmd_if.sink   cmd,
  eit_res_if.source res
);

  localparam int IDX_W = eit_pkg::IDX_W;
  localparam int CNT_W = eit_pkg::CNT_W;
  localparam int SYM_W = eit_pkg::SYM_W;

  logic [SYM_W-1:0] mem [eit_pkg::TAPE_CELLS];

  eit_pkg::seq_state_t state, state_next;

  logic [CNT_W-1:0]           pos, pos_next;
  logic [CNT_W-1:0]           fill, fill_next;
  logic [eit_pkg::CODE_W-1:0] mstate, mstate_next;
  logic                       done, done_next;
  logic                       hit, hit_next;
  logic                       pend, pend_next;
  logic [CNT_W-1:0]           src, src_next;
  logic [CNT_W-1:0]           rem, rem_next;
  logic [IDX_W-1:0]           dst, dst_next;

  logic [eit_pkg::MODE_W-1:0] op;
  logic [SYM_W-1:0]           sym;
  logic                       allowed;
  logic [eit_pkg::CODE_W-1:0] code;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [SYM_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SYM_W-1:0] wr_data;

  logic             bs_ok;
  logic             ins_ok;
  logic             is_ins;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] step_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= eit_pkg::S_IDLE;
      pos    <= '0;
      fill   <= '0;
      mstate <= '0;
      done   <= 1'b0;
      hit    <= 1'b0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      pos    <= pos_next;
      fill   <= fill_next;
      mstate <= mstate_next;
      done   <= done_next;
      hit    <= hit_next;
      pend   <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    src <= src_next;
    rem <= rem_next;
    dst <= dst_next;
    if (cmd.valid && cmd.ready) begin
      op      <= cmd.mode;
      sym     <= cmd.symbol;
      allowed <= cmd.symbol_allowed;
      code    <= cmd.state_code;
    end
  end

  assign bs_ok  = (fill != '0) && (pos != '0) && (pos <= fill);
  assign ins_ok = (fill < eit_pkg::TAPE_LIM) && (pos < eit_pkg::TAPE_LIM) &&
                  (pos <= fill) && allowed;
  assign is_ins = (op == eit_pkg::MODE_INSERT);
  assign span   = fill - pos;
  assign step_pos = (pos < eit_pkg::TAPE_LIM) ? pos + 1'b1 : pos;

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    fill_next   = fill;
    mstate_next = mstate;
    done_next   = done;
    hit_next    = hit;
    pend_next   = pend;
    src_next    = src;
    rem_next    = rem;
    dst_next    = dst;
    rd_en       = 1'b0;
    rd_addr     = src[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = dst;
    wr_data     = rd_data;
    cmd.ready   = 1'b0;
    res.valid   = 1'b0;

    unique case (state)
      eit_pkg::S_IDLE: begin
        cmd.ready = !rst;
        if (cmd.valid && !rst) begin
          state_next = eit_pkg::S_EXEC;
        end
      end

      eit_pkg::S_EXEC: begin
        state_next = eit_pkg::S_LOOK;
        done_next  = 1'b0;
        pend_next  = 1'b0;
        case (op)
          eit_pkg::MODE_CLEAR: begin
            pos_next  = '0;
            fill_next = '0;
          end
          eit_pkg::MODE_LEFT: begin
            if (pos != '0) begin
              pos_next = pos - 1'b1;
            end
          end
          eit_pkg::MODE_RIGHT: begin
            if (pos < fill) begin
              pos_next = pos + 1'b1;
            end
          end
          eit_pkg::MODE_BACKSPACE: begin
            if (bs_ok) begin
              state_next = eit_pkg::S_SHIFT;
              src_next   = pos;
              rem_next   = span;
            end
          end
          eit_pkg::MODE_INSERT: begin
            if (ins_ok) begin
              state_next = eit_pkg::S_SHIFT;
              src_next   = fill - 1'b1;
              rem_next   = span;
            end
          end
          eit_pkg::MODE_START_RUN: begin
            mstate_next = code;
            pos_next    = '0;
          end
          eit_pkg::MODE_RUN_STEP: begin
            mstate_next = code;
            pos_next    = step_pos;
            done_next   = (step_pos >= fill);
          end
          default: begin
          end
        endcase
      end

      eit_pkg::S_SHIFT: begin
        if (rem != '0) begin
          rd_en     = 1'b1;
          src_next  = is_ins ? src - 1'b1 : src + 1'b1;
          rem_next  = rem - 1'b1;
          pend_next = 1'b1;
          dst_next  = is_ins ? src[IDX_W-1:0] + 1'b1 : src[IDX_W-1:0] - 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          wr_en = 1'b1;
        end
        if ((rem == '0) && !pend) begin
          state_next = eit_pkg::S_LOOK;
          if (is_ins) begin
            wr_en     = 1'b1;
            wr_addr   = pos[IDX_W-1:0];
            wr_data   = sym;
            pos_next  = pos + 1'b1;
            fill_next = fill + 1'b1;
          end else begin
            pos_next  = pos - 1'b1;
            fill_next = fill - 1'b1;
          end
        end
      end

      eit_pkg::S_LOOK: begin
        hit_next   = (pos < fill);
        rd_en      = (pos < fill);
        rd_addr    = pos[IDX_W-1:0];
        state_next = eit_pkg::S_RESP;
      end

      eit_pkg::S_RESP: begin
        res.valid = 1'b1;
        if (res.ready) begin
          state_next = eit_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = eit_pkg::S_IDLE;
      end
    endcase
  end

  assign res.cursor        = eit_pkg::POS_W'(pos);
  assign res.length        = eit_pkg::POS_W'(fill);
  assign res.read_symbol   = hit ? rd_data : '0;
  assign res.machine_state = mstate;
  assign res.run_done      = done;
  assign res.can_run       = (fill != '0);

endmodule

// ===== rtl/core/eit_checker.sv =====
// ----------------------------------------------------------------------------
// Editable input tape checker
// Port-level properties of the tape core, bound into the tape core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eit_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic [eit_pkg::POS_W-1:0]    res_cursor,
  input logic [eit_pkg::POS_W-1:0]    res_length,
  input logic [eit_pkg::SYM_W-1:0]    res_read_symbol,
  input logic                         res_run_done,
  input logic                         res_can_run
);

  `ASSERT_CLK(a_one_at_a_time, !(cmd_ready && res_valid), "command taken while result pending")
  `ASSERT_IMPLY(a_busy_after_accept, cmd_valid && cmd_ready, ##1 !cmd_ready, "ready after accept")
  `ASSERT_IMPLY(a_can_run, res_valid, res_can_run == (res_length != '0), "can_run mismatch")
  `ASSERT_IMPLY(a_done_at_end, res_valid && res_run_done, res_cursor >= res_length, "early done")
  `ASSERT_IMPLY(a_blank_past_end, res_valid && (res_cursor >= res_length),
    res_read_symbol == '0, "symbol read past end")

endmodule

bind editable_input_tape_core eit_checker u_eit_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .res_cursor      (res.cursor),
  .res_length      (res.length),
  .res_read_symbol (res.read_symbol),
  .res_run_done    (res.run_done),
  .res_can_run     (res.can_run)
);

// ===== bench/editable_input_tape_core_tb.sv =====
// ----------------------------------------------------------------------------
// Editable input tape core testbench
// Sends edit, run and unused command words to the core with random idle bursts on
// both channels. Each status word is compared field by field against a
// behavioral model of the tape, cursor, length and machine state.
// ----------------------------------------------------------------------------
module editable_input_tape_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE_CELLS = eit_pkg::TAPE_CELLS;
  localparam int MODE_W     = eit_pkg::MODE_W;
  localparam int SYM_W      = eit_pkg::SYM_W;
  localparam int CODE_W     = eit_pkg::CODE_W;
  localparam int POS_W      = eit_pkg::POS_W;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_TAIL     = 100;
  localparam int DRAIN_CYCLES   = 80;
  localparam int STALL_LIMIT    = 2000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic              allowed;
    logic [CODE_W-1:0] code;
  } command_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  length;
    logic [SYM_W-1:0]  read_symbol;
    logic [CODE_W-1:0] machine_state;
    logic              run_done;
    logic              can_run;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  eit_cmd_if cmd ();
  eit_res_if res ();

  editable_input_tape_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd.sink),
    .res (res.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  command_t          command_queue[$];
  status_t           expected_status[$];
  logic [SYM_W-1:0]  tape_mem[TAPE_CELLS];
  int                tape_pos;
  int                tape_len;
  logic [CODE_W-1:0] tape_state;
  int                error_count;
  int                send_gap;
  int                recv_gap;
  int                idle_cycles;

  function automatic bit quiet_phase();
    return command_queue.size() < QUIET_TAIL;
  endfunction

  function automatic status_t advance_tape(command_t c);
    status_t s;
    logic    done;
    done = 1'b0;
    case (c.mode)
      eit_pkg::MODE_CLEAR: begin
        tape_pos = 0;
        tape_len = 0;
      end
      eit_pkg::MODE_LEFT: begin
        if (tape_pos > 0) tape_pos--;
      end
      eit_pkg::MODE_RIGHT: begin
        if (tape_pos < tape_len) tape_pos++;
      end
      eit_pkg::MODE_BACKSPACE: begin
        if (tape_len > 0 && tape_pos > 0 && tape_pos <= tape_len) begin
          for (int i = tape_pos; i < tape_len; i++) tape_mem[i-1] = tape_mem[i];
          tape_len--;
          tape_pos--;
        end
      end
      eit_pkg::MODE_INSERT: begin
        if (tape_len < TAPE_CELLS && tape_pos < TAPE_CELLS && tape_pos <= tape_len &&
            c.allowed) begin
          for (int i = tape_len; i > tape_pos; i--) tape_mem[i] = tape_mem[i-1];
          tape_mem[tape_pos] = c.symbol;
          tape_len++;
          tape_pos++;
        end
      end
      eit_pkg::MODE_START_RUN: begin
        tape_state = c.code;
        tape_pos   = 0;
      end
      eit_pkg::MODE_RUN_STEP: begin
        tape_state = c.code;
        if (tape_pos < TAPE_CELLS) tape_pos++;
        done = (tape_pos >= tape_len);
      end
      default: begin
      end
    endcase
    s.cursor        = POS_W'(tape_pos);
    s.length        = POS_W'(tape_len);
    s.read_symbol   = (tape_pos < tape_len && tape_pos < TAPE_CELLS) ? tape_mem[tape_pos]
                                                                     : '0;
    s.machine_state = tape_state;
    s.run_done      = done;
    s.can_run       = (tape_len > 0);
    return s;
  endfunction

  task automatic queue_command(int mode, int symbol, int allowed, int code);
    command_t c;
    c.mode    = MODE_W'(mode);
    c.symbol  = SYM_W'(symbol);
    c.allowed = 1'(allowed);
    c.code    = CODE_W'(code);
    command_queue.push_back(c);
  endtask

  task automatic queue_edit();
    int                r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(0, 99);
    if (r < 40)      m = eit_pkg::MODE_INSERT;
    else if (r < 55) m = eit_pkg::MODE_LEFT;
    else if (r < 70) m = eit_pkg::MODE_RIGHT;
    else if (r < 90) m = eit_pkg::MODE_BACKSPACE;
    else if (r < 93) m = eit_pkg::MODE_CLEAR;
    else if (r < 96) m = eit_pkg::MODE_START_RUN;
    else             m = eit_pkg::MODE_RUN_STEP;
    queue_command(m, $urandom_range(0, 255), $urandom_range(0, 9) != 0,
                  $urandom_range(0, 255));
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  initial begin
    cmd.valid          = 1'b0;
    cmd.mode           = eit_pkg::MODE_CLEAR;
    cmd.symbol         = '0;
    cmd.symbol_allowed = 1'b0;
    cmd.state_code     = '0;
    res.ready          = 1'b0;
    tape_pos           = 0;
    tape_len           = 0;
    tape_state         = '0;
    error_count        = 0;
    send_gap           = 0;
    recv_gap           = 0;
    idle_cycles        = 0;
    foreach (tape_mem[i]) tape_mem[i] = '0;

    queue_command(eit_pkg::MODE_CLEAR,     8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_LEFT,      8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RIGHT,     8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_BACKSPACE, 8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RUN_STEP,  8'h00, 1'b0, 8'h3C);
    queue_command(eit_pkg::MODE_INSERT,    8'h00, 1'b1, 8'h00);
    queue_command(eit_pkg::MODE_INSERT,    8'hFF, 1'b1, 8'hFF);
    queue_command(eit_pkg::MODE_INSERT,    8'hA5, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_LEFT,      8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_INSERT,    8'h5A, 1'b1, 8'h00);
    queue_command(eit_pkg::MODE_RIGHT,     8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RIGHT,     8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_LEFT,      8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_BACKSPACE, 8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_START_RUN, 8'h00, 1'b0, 8'hFF);
    queue_command(eit_pkg::MODE_BACKSPACE, 8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RUN_STEP,  8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RUN_STEP,  8'h00, 1'b0, 8'h81);
    queue_command(eit_pkg::MODE_RUN_STEP,  8'h00, 1'b0, 8'h7E);
    queue_command(eit_pkg::MODE_BACKSPACE, 8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_INSERT,    8'h11, 1'b1, 8'h00);
    queue_command(MODE_UNUSED,             8'hFF, 1'b1, 8'hFF);
    queue_command(eit_pkg::MODE_CLEAR,     8'h00, 1'b0, 8'h00);
    queue_command(eit_pkg::MODE_RUN_STEP,  8'h00, 1'b0, 8'h01);

    while (command_queue.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_command(eit_pkg::MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1),
                        $urandom_range(0, 255));
          repeat ($urandom_range(64, 68)) begin
            if ($urandom_range(0, 7) == 0)
              queue_command(eit_pkg::MODE_LEFT, $urandom_range(0, 255), 1'b0,
                            $urandom_range(0, 255));
            queue_command(eit_pkg::MODE_INSERT, $urandom_range(0, 255), 1'b1,
                          $urandom_range(0, 255));
          end
        end
        1, 2: begin
          queue_command(eit_pkg::MODE_START_RUN, $urandom_range(0, 255),
                        $urandom_range(0, 1), $urandom_range(0, 255));
          repeat (($urandom_range(0, 5) == 0) ? 70 : $urandom_range(1, 20))
            queue_command(eit_pkg::MODE_RUN_STEP, $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 255));
          repeat ($urandom_range(0, 3)) queue_edit();
        end
        3: begin
          repeat ($urandom_range(1, 8))
            queue_command($urandom_range(0, 7), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 255));
        end
        default: begin
          repeat ($urandom_range(10, 30)) queue_edit();
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (command_queue.size() != 0 || cmd.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_status.size() != 0) begin
      $error("%0d status words never arrived", expected_status.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        c.mode    = cmd.mode;
        c.symbol  = cmd.symbol;
        c.allowed = cmd.symbol_allowed;
        c.code    = cmd.state_code;
        expected_status.push_back(advance_tape(c));
        if (!quiet_phase() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
      end
      if (!cmd.valid || cmd.ready) begin
        if (send_gap == 0 && !quiet_phase() && $urandom_range(0, 15) == 0)
          send_gap = $urandom_range(1, 10);
        if (send_gap > 0 || command_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          cmd.valid <= 1'b0;
        end else begin
          c = command_queue.pop_front();
          cmd.valid          <= 1'b1;
          cmd.mode           <= c.mode;
          cmd.symbol         <= c.symbol;
          cmd.symbol_allowed <= c.allowed;
          cmd.state_code     <= c.code;
        end
      end
    end
  end

  always @(posedge clk) begin
    status_t s;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_status.size() == 0) begin
          $error("status word with nothing expected: cursor %0d length %0d",
                 res.cursor, res.length);
          error_count++;
        end else begin
          s = expected_status.pop_front();
          check_field("cursor",        s.cursor,        res.cursor);
          check_field("length",        s.length,        res.length);
          check_field("read_symbol",   s.read_symbol,   res.read_symbol);
          check_field("machine_state", s.machine_state, res.machine_state);
          check_field("run_done",      s.run_done,      res.run_done);
          check_field("can_run",       s.can_run,       res.can_run);
        end
      end
      if (recv_gap == 0 && !quiet_phase() && $urandom_range(0, 11) == 0)
        recv_gap = $urandom_range(1, 10);
      if (recv_gap > 0) begin
        recv_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
